// File: src/soil_probe_average_and_alarm_defines.svh
// Assertion macros shared by the soil probe averaging and alarm design.
// Used by the files that check their own logic; depends on nothing else.
// Each macro samples on clock and is switched off while reset is high.
`ifndef SOIL_PROBE_AVERAGE_AND_ALARM_DEFINES_SVH
`define SOIL_PROBE_AVERAGE_AND_ALARM_DEFINES_SVH

`ifndef SYNTH
// Checks a property at every rising clock edge outside reset.
`define SPAA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checks that a property holds in the cycle after a condition.
`define SPAA_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);
`else
`define SPAA_ASSERT(lbl, prop, msg)
`define SPAA_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

// File: src/spaa_pkg.sv
// Types and constants of the soil probe averaging and alarm design.
// Used by every module of the block; depends on nothing.
package spaa_pkg;

   // Field widths of the beats.
   localparam int CODE_W  = 12;
   localparam int PH_W    = 11;
   localparam int EC_W    = 9;
   localparam int MOIST_W = 10;
   localparam int ALERT_W = 3;
   localparam int DOSE_W  = 16;

   // Scaling constants: value = (code * full + bias) / 4095.
   localparam int PH_FULL    = 1400;
   localparam int EC_FULL    = 500;
   localparam int MOIST_FULL = 1000;
   localparam int CODE_FULL  = 4095;
   localparam int ROUND_BIAS = 2047;

   // Divider shape: every quotient of this block stays below 2**QUOT_W.
   localparam int QUOT_W      = 11;
   localparam int SCALE_DVD_W = 23;
   localparam int SCALE_DVS_W = 12;

   // Dose rates in 0.1 kg per acre per 0.01 pH.
   localparam int LIME_RATE   = 40;
   localparam int GYPSUM_RATE = 35;
   localparam int DOSE_PROD_W = 17;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_PH_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PH_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EC_HIGH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOIST_LOW = 3'd3;

   localparam logic [PH_W-1:0]    PH_LOW_RESET    = 11'd550;
   localparam logic [PH_W-1:0]    PH_HIGH_RESET   = 11'd750;
   localparam logic [EC_W-1:0]    EC_HIGH_RESET   = 9'd200;
   localparam logic [MOIST_W-1:0] MOIST_LOW_RESET = 10'd250;

   // Alert codes.
   localparam logic [ALERT_W-1:0] ALERT_NONE      = 3'd0;
   localparam logic [ALERT_W-1:0] ALERT_PH_LOW    = 3'd1;
   localparam logic [ALERT_W-1:0] ALERT_PH_HIGH   = 3'd2;
   localparam logic [ALERT_W-1:0] ALERT_EC_HIGH   = 3'd3;
   localparam logic [ALERT_W-1:0] ALERT_MOIST_LOW = 3'd4;

   typedef struct packed {
      logic [CODE_W-1:0] ph_code;
      logic [CODE_W-1:0] ec_code;
      logic [CODE_W-1:0] moist_code;
   } req_type;

   typedef struct packed {
      logic [PH_W-1:0]    ph_mean;
      logic [EC_W-1:0]    ec_mean;
      logic [MOIST_W-1:0] moist_mean;
      logic [ALERT_W-1:0] alert_code;
      logic               buzzer_on;
      logic [DOSE_W-1:0]  lime_dose;
      logic [DOSE_W-1:0]  gypsum_dose;
   } rsp_type;

   typedef struct packed {
      logic [PH_W-1:0]    ph_low;
      logic [PH_W-1:0]    ph_high;
      logic [EC_W-1:0]    ec_high;
      logic [MOIST_W-1:0] moist_low;
   } limits_type;

   // One scaled sample as it sits in the window store.
   typedef struct packed {
      logic [PH_W-1:0]    ph;
      logic [EC_W-1:0]    ec;
      logic [MOIST_W-1:0] moist;
   } sample_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_UPDATE,
      ST_LOAD,
      ST_MEAN,
      ST_FINISH
   } state_type;

endpackage

// File: src/spaa_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on spaa_pkg for the quotient width.
module spaa_serial_div #(
   parameter int DVD_W = 23,
   parameter int DVS_W = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DVD_W-1:0]           dividend,
   input  logic [DVS_W-1:0]           divisor,
   output logic                       done,
   output logic [spaa_pkg::QUOT_W-1:0] quotient
);

   localparam int QW    = spaa_pkg::QUOT_W;
   localparam int CNT_W = $clog2(QW + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]    shift_ff, shift_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   dvs_ext;
   logic [DVS_W:0]   diff;
   logic             qbit;

   // One restoring step: bring down the next dividend bit and try to subtract.
   assign trial   = {rem_ff, shift_ff[QW-1]};
   assign dvs_ext = {1'b0, dvs_ff};
   assign diff    = trial - dvs_ext;
   assign qbit    = (trial >= dvs_ext);

   // The low dividend bits shift out while the quotient bits shift in.
   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         rem_in   = DVS_W'(dividend >> QW);
         shift_in = dividend[QW-1:0];
         dvs_in   = divisor;
      end else if (cnt_ff != '0) begin
         rem_in   = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         shift_in = {shift_ff[QW-2:0], qbit};
      end
   end

   // Step counter and a one-cycle done pulse after the last step.
   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNT_W'(QW);
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      dvs_ff   <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

// File: src/spaa_window.sv
// Window store of the last DEPTH scaled samples with running totals.
// Depends on spaa_pkg for the sample type and the full-scale constants.
`include "soil_probe_average_and_alarm_defines.svh"

module spaa_window #(
   parameter int DEPTH = 50
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   update,
   input  spaa_pkg::sample_type                   sample,
   output logic [$clog2(DEPTH*spaa_pkg::PH_FULL+1)-1:0]    ph_total,
   output logic [$clog2(DEPTH*spaa_pkg::EC_FULL+1)-1:0]    ec_total,
   output logic [$clog2(DEPTH*spaa_pkg::MOIST_FULL+1)-1:0] moist_total,
   output logic [$clog2(DEPTH+1)-1:0]             count
);

   localparam int PH_TOT_W    = $clog2(DEPTH*spaa_pkg::PH_FULL+1);
   localparam int EC_TOT_W    = $clog2(DEPTH*spaa_pkg::EC_FULL+1);
   localparam int MOIST_TOT_W = $clog2(DEPTH*spaa_pkg::MOIST_FULL+1);
   localparam int CNT_W       = $clog2(DEPTH+1);
   localparam int SLOT_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   spaa_pkg::sample_type ring_mem [DEPTH];
   spaa_pkg::sample_type rd_ff;

   logic [PH_TOT_W-1:0]    ph_total_ff, ph_total_in;
   logic [EC_TOT_W-1:0]    ec_total_ff, ec_total_in;
   logic [MOIST_TOT_W-1:0] moist_total_ff, moist_total_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic                   full_ff, full_in;
   logic                   last_slot;

   // The entry at the write slot is read every cycle; it is the oldest sample
   // once the window is full and is written over on the update.
   always_ff @(posedge clock) begin
      if (update) begin
         ring_mem[slot_ff] <= sample;
      end
      rd_ff <= ring_mem[slot_ff];
   end

   assign last_slot = (slot_ff == SLOT_W'(DEPTH - 1));

   // Totals drop the oldest sample when full and add the new one.
   always_comb begin
      ph_total_in    = ph_total_ff;
      ec_total_in    = ec_total_ff;
      moist_total_in = moist_total_ff;
      slot_in        = slot_ff;
      full_in        = full_ff;
      if (update) begin
         ph_total_in    = ph_total_ff + PH_TOT_W'(sample.ph)
                          - (full_ff ? PH_TOT_W'(rd_ff.ph) : '0);
         ec_total_in    = ec_total_ff + EC_TOT_W'(sample.ec)
                          - (full_ff ? EC_TOT_W'(rd_ff.ec) : '0);
         moist_total_in = moist_total_ff + MOIST_TOT_W'(sample.moist)
                          - (full_ff ? MOIST_TOT_W'(rd_ff.moist) : '0);
         if (last_slot) begin
            slot_in = '0;
            full_in = 1'b1;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_total_ff    <= '0;
         ec_total_ff    <= '0;
         moist_total_ff <= '0;
         slot_ff        <= '0;
         full_ff        <= 1'b0;
      end else begin
         ph_total_ff    <= ph_total_in;
         ec_total_ff    <= ec_total_in;
         moist_total_ff <= moist_total_in;
         slot_ff        <= slot_in;
         full_ff        <= full_in;
      end
   end

   assign ph_total    = ph_total_ff;
   assign ec_total    = ec_total_ff;
   assign moist_total = moist_total_ff;
   assign count       = full_ff ? CNT_W'(DEPTH) : CNT_W'(slot_ff);

   `SPAA_ASSERT(a_slot_range, slot_ff <= SLOT_W'(DEPTH - 1), "write slot beyond window depth")
   `SPAA_ASSERT(a_full_sticks, !$fell(full_ff), "window full flag dropped")
   `SPAA_ASSERT_NEXT(a_totals_hold, !update, $stable(ph_total_ff) && $stable(slot_ff), "window changed without an update")

endmodule

// File: src/spaa_alarm.sv
// Alert priority and dose calculation from the three means.
// Depends on spaa_pkg for the result type, limits and alert codes.
module spaa_alarm (
   input  logic [spaa_pkg::PH_W-1:0]    ph_mean,
   input  logic [spaa_pkg::EC_W-1:0]    ec_mean,
   input  logic [spaa_pkg::MOIST_W-1:0] moist_mean,
   input  spaa_pkg::limits_type         limits,
   output spaa_pkg::rsp_type            result
);

   localparam int PW = spaa_pkg::DOSE_PROD_W;
   localparam int DW = spaa_pkg::DOSE_W;

   logic [spaa_pkg::ALERT_W-1:0] alert;
   logic [PW-1:0]                lime_prod;
   logic [PW-1:0]                gypsum_prod;

   // The first rule that fires in priority order sets the alert.
   always_comb begin
      alert       = spaa_pkg::ALERT_NONE;
      lime_prod   = '0;
      gypsum_prod = '0;
      if (ph_mean < limits.ph_low) begin
         alert     = spaa_pkg::ALERT_PH_LOW;
         lime_prod = PW'(limits.ph_low - ph_mean) * PW'(spaa_pkg::LIME_RATE);
      end else if (ph_mean > limits.ph_high) begin
         alert       = spaa_pkg::ALERT_PH_HIGH;
         gypsum_prod = PW'(ph_mean - limits.ph_high) * PW'(spaa_pkg::GYPSUM_RATE);
      end else if (ec_mean > limits.ec_high) begin
         alert = spaa_pkg::ALERT_EC_HIGH;
      end else if (moist_mean < limits.moist_low) begin
         alert = spaa_pkg::ALERT_MOIST_LOW;
      end
   end

   // Doses saturate at the largest 16-bit value.
   always_comb begin
      result.ph_mean     = ph_mean;
      result.ec_mean     = ec_mean;
      result.moist_mean  = moist_mean;
      result.alert_code  = alert;
      result.buzzer_on   = (alert != spaa_pkg::ALERT_NONE);
      result.lime_dose   = (lime_prod[PW-1:DW] != '0) ? '1 : lime_prod[DW-1:0];
      result.gypsum_dose = (gypsum_prod[PW-1:DW] != '0) ? '1 : gypsum_prod[DW-1:0];
   end

endmodule

// File: src/soil_probe_average_and_alarm.sv
// Top level: soil probe moving average with threshold alarm and dose output.
// Depends on spaa_pkg, spaa_serial_div, spaa_window and spaa_alarm.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_data  (three raw ADC codes)
//   rsp      out        rsp_valid / rsp_stall   rsp_data  (means, alert, doses)
//   csr      in         csr_valid / csr_ready   csr_index, csr_wdata
//
// For an item, 11 bit-serial divider steps scale the codes, the window takes the
// sample, the mean operands are loaded, 11 more steps form the rounded means, and
// the result is handed over; the next item is accepted only after that result
// beat is loaded. Synchronous reset empties the window and restores the default
// limits. A stalled result waits in the output register; the block then holds in
// its last step, and req_stall stays high whenever an item is in progress.
`include "soil_probe_average_and_alarm_defines.svh"

module soil_probe_average_and_alarm #(
   parameter int WINDOW_DEPTH = 50
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  spaa_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output spaa_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [spaa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [spaa_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int QW          = spaa_pkg::QUOT_W;
   localparam int PH_TOT_W    = $clog2(WINDOW_DEPTH*spaa_pkg::PH_FULL+1);
   localparam int EC_TOT_W    = $clog2(WINDOW_DEPTH*spaa_pkg::EC_FULL+1);
   localparam int MOIST_TOT_W = $clog2(WINDOW_DEPTH*spaa_pkg::MOIST_FULL+1);
   localparam int CNT_W       = $clog2(WINDOW_DEPTH+1);
   localparam int MEAN_DVD_W  =
      $clog2(WINDOW_DEPTH*spaa_pkg::PH_FULL + WINDOW_DEPTH/2 + 1);
   localparam int DVD_W       =
      (MEAN_DVD_W > spaa_pkg::SCALE_DVD_W) ? MEAN_DVD_W : spaa_pkg::SCALE_DVD_W;
   localparam int DVS_W       =
      (CNT_W > spaa_pkg::SCALE_DVS_W) ? CNT_W : spaa_pkg::SCALE_DVS_W;

   spaa_pkg::state_type  state_ff, state_in;
   spaa_pkg::limits_type limits_ff, limits_in;
   spaa_pkg::rsp_type    rsp_data_ff;
   spaa_pkg::rsp_type    alarm_result;
   spaa_pkg::sample_type sample;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                   div_start;
   logic                   use_mean;
   logic                   win_update;
   logic                   rsp_load;
   logic [DVD_W-1:0]       ph_dvd, ec_dvd, moist_dvd;
   logic [DVS_W-1:0]       dvs;
   logic                   ph_done, ec_done, moist_done;
   logic [QW-1:0]          ph_q, ec_q, moist_q;
   logic [PH_TOT_W-1:0]    ph_total;
   logic [EC_TOT_W-1:0]    ec_total;
   logic [MOIST_TOT_W-1:0] moist_total;
   logic [CNT_W-1:0]       count;

   // Sequencer for one item: scale, update the window, average, hand over.
   always_comb begin
      state_in   = state_ff;
      div_start  = 1'b0;
      use_mean   = 1'b0;
      win_update = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         spaa_pkg::ST_IDLE: begin
            if (req_valid) begin
               div_start = 1'b1;
               state_in  = spaa_pkg::ST_SCALE;
            end
         end
         spaa_pkg::ST_SCALE: begin
            if (ph_done) begin
               state_in = spaa_pkg::ST_UPDATE;
            end
         end
         spaa_pkg::ST_UPDATE: begin
            win_update = 1'b1;
            state_in   = spaa_pkg::ST_LOAD;
         end
         spaa_pkg::ST_LOAD: begin
            div_start = 1'b1;
            use_mean  = 1'b1;
            state_in  = spaa_pkg::ST_MEAN;
         end
         spaa_pkg::ST_MEAN: begin
            if (ph_done) begin
               state_in = spaa_pkg::ST_FINISH;
            end
         end
         spaa_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = spaa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spaa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spaa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != spaa_pkg::ST_IDLE);

   // Divider operands: scaling products on the accepted beat, then the
   // rounded totals over the sample count.
   always_comb begin
      if (use_mean) begin
         ph_dvd    = DVD_W'(ph_total) + DVD_W'(count >> 1);
         ec_dvd    = DVD_W'(ec_total) + DVD_W'(count >> 1);
         moist_dvd = DVD_W'(moist_total) + DVD_W'(count >> 1);
         dvs       = DVS_W'(count);
      end else begin
         ph_dvd    = DVD_W'(req_data.ph_code) * DVD_W'(spaa_pkg::PH_FULL)
                     + DVD_W'(spaa_pkg::ROUND_BIAS);
         ec_dvd    = DVD_W'(req_data.ec_code) * DVD_W'(spaa_pkg::EC_FULL)
                     + DVD_W'(spaa_pkg::ROUND_BIAS);
         moist_dvd = DVD_W'(req_data.moist_code) * DVD_W'(spaa_pkg::MOIST_FULL)
                     + DVD_W'(spaa_pkg::ROUND_BIAS);
         dvs       = DVS_W'(spaa_pkg::CODE_FULL);
      end
   end

   spaa_serial_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_ph_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ph_dvd),
      .divisor  (dvs),
      .done     (ph_done),
      .quotient (ph_q)
   );

   spaa_serial_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_ec_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ec_dvd),
      .divisor  (dvs),
      .done     (ec_done),
      .quotient (ec_q)
   );

   spaa_serial_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_moist_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (moist_dvd),
      .divisor  (dvs),
      .done     (moist_done),
      .quotient (moist_q)
   );

   // Scaled sample; moisture counts down from full scale as the code rises.
   always_comb begin
      sample.ph    = ph_q[spaa_pkg::PH_W-1:0];
      sample.ec    = ec_q[spaa_pkg::EC_W-1:0];
      sample.moist = spaa_pkg::MOIST_W'(spaa_pkg::MOIST_FULL)
                     - moist_q[spaa_pkg::MOIST_W-1:0];
   end

   spaa_window #(.DEPTH(WINDOW_DEPTH)) u_window (
      .clock       (clock),
      .reset       (reset),
      .update      (win_update),
      .sample      (sample),
      .ph_total    (ph_total),
      .ec_total    (ec_total),
      .moist_total (moist_total),
      .count       (count)
   );

   spaa_alarm u_alarm (
      .ph_mean    (ph_q[spaa_pkg::PH_W-1:0]),
      .ec_mean    (ec_q[spaa_pkg::EC_W-1:0]),
      .moist_mean (moist_q[spaa_pkg::MOIST_W-1:0]),
      .limits     (limits_ff),
      .result     (alarm_result)
   );

   // Output register: holds a result beat until it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= alarm_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Limit registers; writes to unused indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      limits_in = limits_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            spaa_pkg::CSR_PH_LOW:    limits_in.ph_low    = csr_wdata[spaa_pkg::PH_W-1:0];
            spaa_pkg::CSR_PH_HIGH:   limits_in.ph_high   = csr_wdata[spaa_pkg::PH_W-1:0];
            spaa_pkg::CSR_EC_HIGH:   limits_in.ec_high   = csr_wdata[spaa_pkg::EC_W-1:0];
            spaa_pkg::CSR_MOIST_LOW: limits_in.moist_low = csr_wdata[spaa_pkg::MOIST_W-1:0];
            default: begin
               limits_in = limits_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.ph_low    <= spaa_pkg::PH_LOW_RESET;
         limits_ff.ph_high   <= spaa_pkg::PH_HIGH_RESET;
         limits_ff.ec_high   <= spaa_pkg::EC_HIGH_RESET;
         limits_ff.moist_low <= spaa_pkg::MOIST_LOW_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

   `SPAA_ASSERT(a_lanes_lockstep, (ph_done == ec_done) && (ph_done == moist_done), "divider lanes out of step")
   `SPAA_ASSERT(a_scale_latency, (state_ff == spaa_pkg::ST_IDLE) && req_valid |-> ##(spaa_pkg::QUOT_W + 1) ph_done, "scaling pass did not finish on time")
   `SPAA_ASSERT(a_rsp_from_finish, $rose(rsp_valid_ff) |-> $past(state_ff == spaa_pkg::ST_FINISH), "result beat loaded outside the last step")

endmodule
